// File: rtl/core/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared types and constants of the CEC bit receiver: bit timing limits,
// result kind codes, configuration register indexes and the event group
// passed from decoder to emitter.
`default_nettype none

package cbr_pkg;

  // timing limits in microseconds
  localparam logic [31:0] SILENCE_US     = 32'd6100;
  localparam logic [31:0] START_LIMIT_US = 32'd3500;
  localparam logic [31:0] GLITCH_US      = 32'd100;
  localparam logic [31:0] ONE_MAX_US     = 32'd800;

  localparam logic [3:0] BCAST_ADDR = 4'hF;

  // result kinds
  localparam logic [1:0] KIND_ACT  = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_BLK  = 2'd2;
  localparam logic [1:0] KIND_BYTE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_ADDR = 2'd0;
  localparam logic [1:0] REG_MONITOR  = 2'd1;
  localparam logic [1:0] REG_PROMISC  = 2'd2;

  // results requested by one decoded edge
  typedef struct packed {
    logic act;      // bus activity start
    logic ack;      // drive ack now
    logic blk;      // block done
    logic eom;
    logic ack_lvl;
    logic dump;     // emit the stored frame
  } cbr_evt_t;

endpackage

`default_nettype wire

// File: rtl/core/cec_bit_receiver.sv
// ----------------------------------------------------------------------------
// cec_bit_receiver
// CEC bit receiver: decodes bus line edges into bits, blocks and frames.
// ----------------------------------------------------------------------------
// Each edge request is captured in an input register and decoded in the
// next cycle, so an edge that causes no result is done once it is decoded.
// Every result then passes through the pending register of the emitter and
// the output register, and each byte of an accepted frame is fetched
// through a read state and a wait state, as the read port of the frame RAM
// is registered. in_stall_o stays high until the last result of an edge
// has been handed to the output register, which holds it until the
// receiver takes it. The frame RAM needs no clearing after reset: only
// bytes written during the current frame are read back. Configuration sits
// behind an APB port at byte addresses 0 (own address), 4 (monitor mode)
// and 8 (promiscuous mode).
// ----------------------------------------------------------------------------
`default_nettype none

module cec_bit_receiver #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // edge requests
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] edge_time_us_i,
  input  wire logic        line_level_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [1:0]  event_kind_o,
  output logic             block_eom_o,
  output logic             block_ack_level_o,
  output logic      [7:0]  frame_data_o,
  output logic             frame_last_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

  logic        hold_q, hold_d;
  logic [31:0] time_q;
  logic        level_q;

  logic [3:0]  own_q, own_d;
  logic        mon_q, mon_d;
  logic        prom_q, prom_d;

  logic              evt_vld;
  cbr_pkg::cbr_evt_t evt;
  logic [CW-1:0]     dump_count;
  logic              emit_busy;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  logic        in_acc;
  logic        cfg_wr;

  assign in_stall_o = hold_q || emit_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign hold_d     = in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      time_q  <= edge_time_us_i;
      level_q <= line_level_i;
    end
  end

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    own_d  = own_q;
    mon_d  = mon_q;
    prom_d = prom_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        cbr_pkg::REG_OWN_ADDR: own_d  = pwdata[3:0];
        cbr_pkg::REG_MONITOR:  mon_d  = pwdata[0];
        cbr_pkg::REG_PROMISC:  prom_d = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cbr_pkg::REG_OWN_ADDR: prdata = {28'd0, own_q};
      cbr_pkg::REG_MONITOR:  prdata = {31'd0, mon_q};
      cbr_pkg::REG_PROMISC:  prdata = {31'd0, prom_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q  <= 4'hF;
      mon_q  <= 1'b0;
      prom_q <= 1'b0;
    end else begin
      own_q  <= own_d;
      mon_q  <= mon_d;
      prom_q <= prom_d;
    end
  end

  cbr_decode #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_vld_i   (hold_q),
    .time_i       (time_q),
    .level_i      (level_q),
    .own_addr_i   (own_q),
    .monitor_i    (mon_q),
    .promisc_i    (prom_q),
    .evt_vld_o    (evt_vld),
    .evt_o        (evt),
    .dump_count_o (dump_count),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  cbr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cbr_emit #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .evt_vld_i         (evt_vld),
    .evt_i             (evt),
    .dump_count_i      (dump_count),
    .busy_o            (emit_busy),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_kind_o      (event_kind_o),
    .block_eom_o       (block_eom_o),
    .block_ack_level_o (block_ack_level_o),
    .frame_data_o      (frame_data_o),
    .frame_last_o      (frame_last_o)
  );

  // an accepted edge keeps the input side closed while it is decoded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held off after edge request");

  a_last_only_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> event_kind_o == cbr_pkg::KIND_BYTE)
    else $error("frame_last on a non-byte result");

  a_block_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (block_eom_o || block_ack_level_o)
    |-> event_kind_o == cbr_pkg::KIND_BLK)
    else $error("block fields set on a non-block result");

  a_data_only_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != cbr_pkg::KIND_BYTE) |-> frame_data_o == 8'd0)
    else $error("frame data set on a non-byte result");

endmodule

`default_nettype wire

// File: rtl/core/cbr_ram.sv
// ----------------------------------------------------------------------------
// cbr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/cbr_decode.sv
// ----------------------------------------------------------------------------
// cbr_decode
// Edge decoder: measures low pulses, tracks the receive phase, assembles
// bytes into the frame RAM and requests results from the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_decode #(
  parameter int MAX_FRAME_BYTES = 16,
  localparam int AW = $clog2(MAX_FRAME_BYTES),
  localparam int CW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_vld_i,
  input  wire logic [31:0]      time_i,
  input  wire logic             level_i,
  input  wire logic [3:0]       own_addr_i,
  input  wire logic             monitor_i,
  input  wire logic             promisc_i,
  output logic                  evt_vld_o,
  output cbr_pkg::cbr_evt_t     evt_o,
  output logic      [CW-1:0]    dump_count_o,
  output logic                  ram_we_o,
  output logic      [AW-1:0]    ram_waddr_o,
  output logic      [7:0]       ram_wdata_o
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_BYTE    = 3'd1;
  localparam logic [2:0] PH_EOM     = 3'd2;
  localparam logic [2:0] PH_ACK     = 3'd3;
  localparam logic [2:0] PH_EOM_ACK = 3'd4;

  logic          prev_q, prev_d;
  logic [31:0]   fall_q, fall_d;
  logic [2:0]    phase_q, phase_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [7:0]    shift_q, shift_d;
  logic          ack_pend_q, ack_pend_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    hdr_q, hdr_d;

  logic [31:0]   delta;
  logic          bit_val;
  logic [7:0]    shift_n;
  logic [3:0]    dest;
  logic [3:0]    init;
  logic          have_hdr;
  logic          room;

  assign delta    = time_i - fall_q;
  assign bit_val  = (delta <= cbr_pkg::ONE_MAX_US);
  assign shift_n  = {shift_q[6:0], bit_val};
  assign dest     = hdr_q[3:0];
  assign init     = hdr_q[7:4];
  assign have_hdr = (count_q != '0);
  assign room     = (count_q < CW'(MAX_FRAME_BYTES));

  always_comb begin
    prev_d       = prev_q;
    fall_d       = fall_q;
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    shift_d      = shift_q;
    ack_pend_d   = ack_pend_q;
    count_d      = count_q;
    hdr_d        = hdr_q;
    evt_o        = '0;
    evt_vld_o    = 1'b0;
    dump_count_o = count_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = count_q[AW-1:0];
    ram_wdata_o  = shift_n;

    if (item_vld_i && (level_i != prev_q)) begin
      prev_d    = level_i;
      evt_vld_o = 1'b1;
      if (!level_i) begin
        // falling edge: long silence drops any frame in progress
        fall_d = time_i;
        if (delta > cbr_pkg::SILENCE_US) begin
          phase_d    = PH_IDLE;
          cnt_d      = '0;
          shift_d    = '0;
          ack_pend_d = 1'b0;
          count_d    = '0;
          evt_o.act  = 1'b1;
        end else begin
          evt_o.act = (phase_q == PH_IDLE);
          if (ack_pend_q && !monitor_i) begin
            evt_o.ack  = 1'b1;
            ack_pend_d = 1'b0;
          end
        end
      end else if (delta > cbr_pkg::START_LIMIT_US) begin
        phase_d    = PH_BYTE;
        cnt_d      = '0;
        shift_d    = '0;
        ack_pend_d = 1'b0;
        count_d    = '0;
      end else if (delta >= cbr_pkg::GLITCH_US) begin
        case (phase_q)
          PH_BYTE: begin
            shift_d = shift_n;
            cnt_d   = cnt_q + 3'd1;
            if (cnt_q == 3'd7) begin
              if (room) begin
                ram_we_o = 1'b1;
                count_d  = count_q + CW'(1);
                if (!have_hdr) begin
                  hdr_d = shift_n;
                end
              end
              shift_d = '0;
              phase_d = PH_EOM;
            end
          end
          PH_EOM: begin
            if (have_hdr && (dest != cbr_pkg::BCAST_ADDR) && (dest == own_addr_i)
                && (init != own_addr_i)) begin
              ack_pend_d = 1'b1;
            end
            phase_d = bit_val ? PH_EOM_ACK : PH_ACK;
          end
          PH_ACK: begin
            evt_o.blk     = 1'b1;
            evt_o.ack_lvl = bit_val;
            phase_d       = PH_BYTE;
          end
          PH_EOM_ACK: begin
            evt_o.blk     = 1'b1;
            evt_o.eom     = 1'b1;
            evt_o.ack_lvl = bit_val;
            evt_o.dump    = have_hdr && (promisc_i || (dest == own_addr_i)
                            || ((dest == cbr_pkg::BCAST_ADDR) && (init != own_addr_i)));
            phase_d    = PH_IDLE;
            cnt_d      = '0;
            shift_d    = '0;
            ack_pend_d = 1'b0;
            count_d    = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 1'b1;
      fall_q     <= '0;
      phase_q    <= PH_IDLE;
      cnt_q      <= '0;
      shift_q    <= '0;
      ack_pend_q <= 1'b0;
      count_q    <= '0;
    end else begin
      prev_q     <= prev_d;
      fall_q     <= fall_d;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      ack_pend_q <= ack_pend_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/cbr_emit.sv
// ----------------------------------------------------------------------------
// cbr_emit
// Result sequencer: holds the results requested by one edge, reads stored
// frame bytes back from the frame RAM and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_emit #(
  parameter int MAX_FRAME_BYTES = 16,
  localparam int AW = $clog2(MAX_FRAME_BYTES),
  localparam int CW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              evt_vld_i,
  input  wire cbr_pkg::cbr_evt_t evt_i,
  input  wire logic [CW-1:0]     dump_count_i,
  output logic                   busy_o,
  output logic                   ram_re_o,
  output logic      [AW-1:0]     ram_raddr_o,
  input  wire logic [7:0]        ram_rdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [1:0]        event_kind_o,
  output logic                   block_eom_o,
  output logic                   block_ack_level_o,
  output logic      [7:0]        frame_data_o,
  output logic                   frame_last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WT   = 2'd2;

  logic [1:0]        state_q, state_d;
  cbr_pkg::cbr_evt_t pend_q, pend_d;
  logic [CW-1:0]     dcnt_q, dcnt_d;
  logic [AW-1:0]     idx_q, idx_d;

  logic              ov_q, ov_d;
  logic [1:0]        kind_q, kind_d;
  logic              eom_q, eom_d;
  logic              ackl_q, ackl_d;
  logic [7:0]        data_q, data_d;
  logic              last_q, last_d;

  logic              out_free;
  logic              is_last;

  assign out_free = !ov_q || !out_stall_i;
  assign is_last  = ((CW'(idx_q) + CW'(1)) == dcnt_q);

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    dcnt_d      = dcnt_q;
    idx_d       = idx_q;
    ov_d        = ov_q && out_stall_i;
    kind_d      = kind_q;
    eom_d       = eom_q;
    ackl_d      = ackl_q;
    data_d      = data_q;
    last_d      = last_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;

    if (evt_vld_i) begin
      pend_d = evt_i;
      dcnt_d = dump_count_i;
      idx_d  = '0;
    end

    case (state_q)
      ST_IDLE: begin
        if (out_free) begin
          if (pend_q.act || pend_q.ack || pend_q.blk) begin
            ov_d   = 1'b1;
            eom_d  = 1'b0;
            ackl_d = 1'b0;
            data_d = '0;
            last_d = 1'b0;
            if (pend_q.act) begin
              kind_d     = cbr_pkg::KIND_ACT;
              pend_d.act = 1'b0;
            end else if (pend_q.ack) begin
              kind_d     = cbr_pkg::KIND_ACK;
              pend_d.ack = 1'b0;
            end else begin
              kind_d     = cbr_pkg::KIND_BLK;
              eom_d      = pend_q.eom;
              ackl_d     = pend_q.ack_lvl;
              pend_d.blk = 1'b0;
            end
          end else if (pend_q.dump) begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_re_o = 1'b1;
        state_d  = ST_WT;
      end
      ST_WT: begin
        // read data stays put until the next read request
        if (out_free) begin
          ov_d   = 1'b1;
          kind_d = cbr_pkg::KIND_BYTE;
          eom_d  = 1'b0;
          ackl_d = 1'b0;
          data_d = ram_rdata_i;
          last_d = is_last;
          if (is_last) begin
            pend_d.dump = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dcnt_q <= dcnt_d;
    idx_q  <= idx_d;
    kind_q <= kind_d;
    eom_q  <= eom_d;
    ackl_q <= ackl_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  assign busy_o            = pend_q.act || pend_q.ack || pend_q.blk || pend_q.dump
                             || (state_q != ST_IDLE);
  assign out_valid_o       = ov_q;
  assign event_kind_o      = kind_q;
  assign block_eom_o       = eom_q;
  assign block_ack_level_o = ackl_q;
  assign frame_data_o      = data_q;
  assign frame_last_o      = last_q;

endmodule

`default_nettype wire
